FILE: rtl/breakpoint_watchpoint_table_top_assert.svh
// ----------------------------------------------------------------------------
// Breakpoint/watchpoint table assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_WATCHPOINT_TABLE_TOP_ASSERT_SVH
`define BREAKPOINT_WATCHPOINT_TABLE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BWT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bwt assertion failed");
// next-cycle implication
`define BWT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bwt assertion failed");
`else
`define BWT_ASSERT_NOW(lbl, pre, post)
`define BWT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: rtl/bwt_pkg.sv
// ----------------------------------------------------------------------------
// bwt_pkg
// Codes, fixed field widths and shared types of the breakpoint/watchpoint table.
// ----------------------------------------------------------------------------
package bwt_pkg;

  localparam int OPCODE_W = 3;
  localparam int KIND_W   = 3;
  localparam int LEN_W    = 16;
  localparam int HITS_W   = 16;
  localparam int STATUS_W = 3;
  localparam int IDXO_W   = 4;
  localparam int BASEO_W  = 32;
  localparam int INADDR_W = 32;
  localparam int MASK_W   = 4;
  localparam int ILEN_W   = 5;
  localparam int LIMIT_W  = 5;
  localparam int CFGD_W   = 5;
  localparam int CFGI_W   = 2;

  localparam logic [OPCODE_W-1:0] OP_SET    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_WATCH  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISALIGN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_WATCH  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERLAP   = 3'd5;

  localparam logic [KIND_W-1:0] KIND_INSTR    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACCESS   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PHYSICAL = 3'd4;

  localparam logic [CFGI_W-1:0] REG_EXACT  = 2'd0;
  localparam logic [CFGI_W-1:0] REG_ALIGN  = 2'd1;
  localparam logic [CFGI_W-1:0] REG_ILEN   = 2'd2;
  localparam logic [CFGI_W-1:0] REG_WLIMIT = 2'd3;

  // broadcast to every cell
  typedef struct packed {
    logic clear_all;
    logic free_en;
    logic write_en;
    logic exact;
  } cmd_t;

  // fixed-width part of a match handed along the chain
  typedef struct packed {
    logic              found;
    logic [KIND_W-1:0] kind;
    logic [HITS_W-1:0] hits;
    logic              temp;
  } hit_t;

  function automatic logic is_watch(input logic [KIND_W-1:0] kind);
    return (kind >= KIND_ACCESS) && (kind <= KIND_PHYSICAL);
  endfunction

endpackage

FILE: rtl/bwt_cell.sv
// ----------------------------------------------------------------------------
// bwt_cell
// One table entry with its comparators; passes first-match results onward.
// ----------------------------------------------------------------------------
module bwt_cell #(
  parameter int AW  = 32,
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bwt_pkg::cmd_t               cmd,
  input  logic [AW-1:0]               req_addr,
  input  logic [bwt_pkg::LEN_W-1:0]   req_len,
  input  logic [bwt_pkg::KIND_W-1:0]  req_kind,
  input  logic [bwt_pkg::HITS_W-1:0]  req_hits,
  input  logic                        req_temp,
  input  bwt_pkg::hit_t               gen_in,
  input  logic [IW-1:0]               gen_idx_in,
  input  logic [AW-1:0]               gen_base_in,
  output bwt_pkg::hit_t               gen_out,
  output logic [IW-1:0]               gen_idx_out,
  output logic [AW-1:0]               gen_base_out,
  input  bwt_pkg::hit_t               wat_in,
  input  logic [IW-1:0]               wat_idx_in,
  input  logic [AW-1:0]               wat_base_in,
  output bwt_pkg::hit_t               wat_out,
  output logic [IW-1:0]               wat_idx_out,
  output logic [AW-1:0]               wat_base_out,
  input  logic                        free_in,
  input  logic [IW-1:0]               free_idx_in,
  output logic                        free_out,
  output logic [IW-1:0]               free_idx_out,
  input  logic                        ovl_in,
  output logic                        ovl_out,
  output logic                        valid_o
);

  logic                       valid_r;
  logic                       temp_r;
  logic [AW-1:0]              addr_r;
  logic [bwt_pkg::LEN_W-1:0]  len_r;
  logic [bwt_pkg::KIND_W-1:0] kind_r;
  logic [bwt_pkg::HITS_W-1:0] hits_r;

  logic          covers;
  logic          gen_match;
  logic          wat_match;
  logic          gen_sel;
  logic          wat_sel;
  logic          free_sel;
  logic          ovl_here;
  bwt_pkg::hit_t mine;
  logic [IW-1:0] my_idx;

  assign my_idx = IW'(IDX);
  assign mine   = '{found: 1'b1, kind: kind_r, hits: hits_r, temp: temp_r};

  assign covers    = (req_addr >= addr_r) && ((req_addr - addr_r) < AW'(len_r));
  assign gen_match = valid_r && (cmd.exact ? (addr_r == req_addr) : covers);
  assign wat_match = valid_r && bwt_pkg::is_watch(kind_r) && covers;
  assign gen_sel   = gen_match && !gen_in.found;
  assign wat_sel   = wat_match && !wat_in.found;
  assign free_sel  = !valid_r && !free_in;

  // ranges overlap only when both are non-empty
  always_comb begin
    ovl_here = 1'b0;
    if (valid_r && (req_len != '0) && (len_r != '0)) begin
      if (req_addr <= addr_r) begin
        ovl_here = (addr_r - req_addr) < AW'(req_len);
      end else begin
        ovl_here = (req_addr - addr_r) < AW'(len_r);
      end
    end
  end

  // lowest index wins: pass the earlier winner, else take this entry
  assign gen_out      = gen_sel ? mine : gen_in;
  assign gen_idx_out  = gen_sel ? my_idx : gen_idx_in;
  assign gen_base_out = gen_sel ? addr_r : gen_base_in;
  assign wat_out      = wat_sel ? mine : wat_in;
  assign wat_idx_out  = wat_sel ? my_idx : wat_idx_in;
  assign wat_base_out = wat_sel ? addr_r : wat_base_in;
  assign free_out     = free_in || !valid_r;
  assign free_idx_out = free_sel ? my_idx : free_idx_in;
  assign ovl_out      = ovl_in || ovl_here;
  assign valid_o      = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      temp_r  <= 1'b0;
    end else if (cmd.clear_all || (cmd.free_en && gen_sel)) begin
      valid_r <= 1'b0;
      temp_r  <= 1'b0;
    end else if (cmd.write_en && free_sel) begin
      valid_r <= 1'b1;
      temp_r  <= req_temp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_en && free_sel) begin
      addr_r <= req_addr;
      len_r  <= req_len;
      kind_r <= req_kind;
      hits_r <= req_hits;
    end
  end

endmodule

FILE: rtl/breakpoint_watchpoint_table_top.sv
// ----------------------------------------------------------------------------
// breakpoint_watchpoint_table_top
// Breakpoint and watchpoint table built as a chain of entry cells.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  in_      in   in_tvalid/tready   tuser: opcode, bp_type; tdata: address,
//                                   length, repeat_count, temporary
//  out_     out  out_tvalid/tready  tuser: status, hit; tdata: entry_index,
//                                   entry_type, entry_base, entry_count,
//                                   entry_temporary
//  cfg_     in   cfg_we             cfg_index selects, cfg_wdata carries value
//
//  Delete, clear all and both lookups are accepted and then make one pass
//  through the cell chain. For set, the first pass frees a covering entry
//  and checks alignment and the watch limit, the second picks the lowest
//  free cell and checks overlap against all valid cells.
//  The critical path is the first-match ripple through all ENTRIES cells.
//  The result sits in an output register; a new request is accepted while it
//  waits, but its chain pass holds until the output register frees up.
//  Reset empties the table directly; there is no clearing pass.
// ----------------------------------------------------------------------------
module breakpoint_watchpoint_table_top #(
  parameter int ENTRIES      = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // address[31:0], length[47:32],
                                  // repeat_count[63:48], temporary[64], zero fill
  input  logic [5:0]  in_tuser,   // opcode[2:0], bp_type[5:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // entry_index[3:0], entry_type[6:4],
                                  // entry_base[38:7], entry_count[54:39],
                                  // entry_temporary[55]
  output logic [3:0]  out_tuser,  // status[2:0], hit[3]
  input  logic        cfg_we,
  input  logic [bwt_pkg::CFGI_W-1:0] cfg_index,
  input  logic [bwt_pkg::CFGD_W-1:0] cfg_wdata
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int WCW = $clog2(ENTRIES + 1);
  localparam int LW  = (WCW > bwt_pkg::LIMIT_W) ? WCW : bwt_pkg::LIMIT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FIND  = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;

  // configuration registers
  logic                         exact_r;
  logic [bwt_pkg::MASK_W-1:0]   align_mask_r;
  logic [bwt_pkg::ILEN_W-1:0]   instr_len_r;
  logic [bwt_pkg::LIMIT_W-1:0]  watch_limit_r;

  // control
  logic [1:0]     state_r, state_nxt;
  logic [WCW-1:0] wc_r, wc_nxt;

  // held request
  logic [bwt_pkg::OPCODE_W-1:0] op_r;
  logic [ADDRESS_BITS-1:0]      addr_r;
  logic [bwt_pkg::KIND_W-1:0]   kind_r;
  logic [bwt_pkg::LEN_W-1:0]    len_r;
  logic [bwt_pkg::HITS_W-1:0]   cnt_r;
  logic                         tmp_r;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [bwt_pkg::STATUS_W-1:0]  o_status_r, o_status_nxt;
  logic                          o_hit_r, o_hit_nxt;
  logic [bwt_pkg::IDXO_W-1:0]    o_idx_r, o_idx_nxt;
  logic [bwt_pkg::KIND_W-1:0]    o_kind_r, o_kind_nxt;
  logic [bwt_pkg::BASEO_W-1:0]   o_base_r, o_base_nxt;
  logic [bwt_pkg::HITS_W-1:0]    o_cnt_r, o_cnt_nxt;
  logic                          o_temp_r, o_temp_nxt;
  logic                          emit;

  // chain wiring, one slot more than cells
  bwt_pkg::hit_t           gen_c      [ENTRIES+1];
  logic [IW-1:0]           gen_idx_c  [ENTRIES+1];
  logic [ADDRESS_BITS-1:0] gen_base_c [ENTRIES+1];
  bwt_pkg::hit_t           wat_c      [ENTRIES+1];
  logic [IW-1:0]           wat_idx_c  [ENTRIES+1];
  logic [ADDRESS_BITS-1:0] wat_base_c [ENTRIES+1];
  logic                    free_c     [ENTRIES+1];
  logic [IW-1:0]           free_idx_c [ENTRIES+1];
  logic                    ovl_c      [ENTRIES+1];
  logic [ENTRIES-1:0]      valid_vec;

  bwt_pkg::cmd_t            cmd;
  logic                     go;
  logic [bwt_pkg::LEN_W-1:0] len_eff;
  logic                     misalign;
  logic                     freed_watch;
  logic [WCW-1:0]           wc_after;
  logic                     no_watch;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = {o_hit_r, o_status_r};
  assign out_tdata  = {o_temp_r, o_cnt_r, o_base_r, o_kind_r, o_idx_r};

  // the chain pass may only retire when the output register can take it
  assign go = !out_valid_r || out_tready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exact_r       <= 1'b0;
      align_mask_r  <= 4'd3;
      instr_len_r   <= 5'd4;
      watch_limit_r <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        bwt_pkg::REG_EXACT:  exact_r       <= cfg_wdata[0];
        bwt_pkg::REG_ALIGN:  align_mask_r  <= cfg_wdata[bwt_pkg::MASK_W-1:0];
        bwt_pkg::REG_ILEN:   instr_len_r   <= cfg_wdata;
        bwt_pkg::REG_WLIMIT: watch_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- request capture ----------------
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tuser[2:0];
      kind_r <= in_tuser[5:3];
      addr_r <= ADDRESS_BITS'(in_tdata[31:0]);
      len_r  <= in_tdata[47:32];
      cnt_r  <= in_tdata[63:48];
      tmp_r  <= in_tdata[64];
    end
  end

  // ---------------- cell chain ----------------
  assign gen_c[0]      = '0;
  assign gen_idx_c[0]  = '0;
  assign gen_base_c[0] = '0;
  assign wat_c[0]      = '0;
  assign wat_idx_c[0]  = '0;
  assign wat_base_c[0] = '0;
  assign free_c[0]     = 1'b0;
  assign free_idx_c[0] = '0;
  assign ovl_c[0]      = 1'b0;

  // instruction entries cover the configured instruction length
  assign len_eff = (kind_r == bwt_pkg::KIND_INSTR) ? bwt_pkg::LEN_W'(instr_len_r) : len_r;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bwt_cell #(
      .AW  (ADDRESS_BITS),
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .req_addr     (addr_r),
      .req_len      (len_eff),
      .req_kind     (kind_r),
      .req_hits     (cnt_r),
      .req_temp     (tmp_r),
      .gen_in       (gen_c[g]),
      .gen_idx_in   (gen_idx_c[g]),
      .gen_base_in  (gen_base_c[g]),
      .gen_out      (gen_c[g+1]),
      .gen_idx_out  (gen_idx_c[g+1]),
      .gen_base_out (gen_base_c[g+1]),
      .wat_in       (wat_c[g]),
      .wat_idx_in   (wat_idx_c[g]),
      .wat_base_in  (wat_base_c[g]),
      .wat_out      (wat_c[g+1]),
      .wat_idx_out  (wat_idx_c[g+1]),
      .wat_base_out (wat_base_c[g+1]),
      .free_in      (free_c[g]),
      .free_idx_in  (free_idx_c[g]),
      .free_out     (free_c[g+1]),
      .free_idx_out (free_idx_c[g+1]),
      .ovl_in       (ovl_c[g]),
      .ovl_out      (ovl_c[g+1]),
      .valid_o      (valid_vec[g])
    );
  end

  // ---------------- set checks ----------------
  assign misalign    = (kind_r == bwt_pkg::KIND_INSTR) &&
                       ((addr_r[bwt_pkg::MASK_W-1:0] & align_mask_r) != '0);
  assign freed_watch = gen_c[ENTRIES].found && bwt_pkg::is_watch(gen_c[ENTRIES].kind);
  // count after the covering entry (if any) is freed; never below zero
  assign wc_after    = (freed_watch && (wc_r != '0)) ? wc_r - WCW'(1) : wc_r;
  assign no_watch    = bwt_pkg::is_watch(kind_r) && (LW'(wc_after) >= LW'(watch_limit_r));

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt    = state_r;
    wc_nxt       = wc_r;
    emit         = 1'b0;
    cmd          = '{clear_all: 1'b0, free_en: 1'b0, write_en: 1'b0, exact: exact_r};
    o_status_nxt = bwt_pkg::ST_OK;
    o_hit_nxt    = 1'b0;
    o_idx_nxt    = '0;
    o_kind_nxt   = '0;
    o_base_nxt   = '0;
    o_cnt_nxt    = '0;
    o_temp_nxt   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_FIND;
        end
      end

      S_FIND: begin
        if (go) begin
          state_nxt = S_IDLE;
          case (op_r)
            bwt_pkg::OP_SET: begin
              // drop any entry already covering the address, even if set fails
              cmd.free_en = 1'b1;
              wc_nxt      = wc_after;
              if (misalign) begin
                emit         = 1'b1;
                o_status_nxt = bwt_pkg::ST_MISALIGN;
              end else if (no_watch) begin
                emit         = 1'b1;
                o_status_nxt = bwt_pkg::ST_NO_WATCH;
              end else begin
                state_nxt = S_PLACE;
              end
            end
            bwt_pkg::OP_DELETE: begin
              emit = 1'b1;
              if (gen_c[ENTRIES].found) begin
                cmd.free_en = 1'b1;
                wc_nxt      = wc_after;
                o_hit_nxt   = 1'b1;
                o_idx_nxt   = bwt_pkg::IDXO_W'(gen_idx_c[ENTRIES]);
                o_kind_nxt  = gen_c[ENTRIES].kind;
                o_base_nxt  = bwt_pkg::BASEO_W'(gen_base_c[ENTRIES]);
                o_cnt_nxt   = gen_c[ENTRIES].hits;
                o_temp_nxt  = gen_c[ENTRIES].temp;
              end else begin
                o_status_nxt = bwt_pkg::ST_NOT_FOUND;
              end
            end
            bwt_pkg::OP_CLEAR: begin
              emit          = 1'b1;
              cmd.clear_all = 1'b1;
              wc_nxt        = '0;
            end
            bwt_pkg::OP_LOOKUP: begin
              emit = 1'b1;
              if (gen_c[ENTRIES].found) begin
                o_hit_nxt  = 1'b1;
                o_idx_nxt  = bwt_pkg::IDXO_W'(gen_idx_c[ENTRIES]);
                o_kind_nxt = gen_c[ENTRIES].kind;
                o_base_nxt = bwt_pkg::BASEO_W'(gen_base_c[ENTRIES]);
                o_cnt_nxt  = gen_c[ENTRIES].hits;
                o_temp_nxt = gen_c[ENTRIES].temp;
              end else begin
                o_status_nxt = bwt_pkg::ST_NOT_FOUND;
              end
            end
            bwt_pkg::OP_WATCH: begin
              emit = 1'b1;
              if (wat_c[ENTRIES].found) begin
                o_hit_nxt  = 1'b1;
                o_idx_nxt  = bwt_pkg::IDXO_W'(wat_idx_c[ENTRIES]);
                o_kind_nxt = wat_c[ENTRIES].kind;
                o_base_nxt = bwt_pkg::BASEO_W'(wat_base_c[ENTRIES]);
                o_cnt_nxt  = wat_c[ENTRIES].hits;
                o_temp_nxt = wat_c[ENTRIES].temp;
              end else begin
                o_status_nxt = bwt_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              // unused opcodes answer ok with all fields zero
              emit = 1'b1;
            end
          endcase
        end
      end

      S_PLACE: begin
        if (go) begin
          state_nxt = S_IDLE;
          emit      = 1'b1;
          if (!free_c[ENTRIES]) begin
            o_status_nxt = bwt_pkg::ST_FULL;
          end else if (ovl_c[ENTRIES]) begin
            o_status_nxt = bwt_pkg::ST_OVERLAP;
          end else begin
            cmd.write_en = 1'b1;
            if (bwt_pkg::is_watch(kind_r)) begin
              wc_nxt = wc_r + WCW'(1);
            end
            o_idx_nxt  = bwt_pkg::IDXO_W'(free_idx_c[ENTRIES]);
            o_kind_nxt = kind_r;
            o_base_nxt = bwt_pkg::BASEO_W'(addr_r);
            o_cnt_nxt  = cnt_r;
            o_temp_nxt = tmp_r;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold the result until taken, replace it when a new one retires
  assign out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_status_r <= o_status_nxt;
      o_hit_r    <= o_hit_nxt;
      o_idx_r    <= o_idx_nxt;
      o_kind_r   <= o_kind_nxt;
      o_base_r   <= o_base_nxt;
      o_cnt_r    <= o_cnt_nxt;
      o_temp_r   <= o_temp_nxt;
    end
  end

  // ---------------- assertions ----------------
`include "breakpoint_watchpoint_table_top_assert.svh"

  `BWT_ASSERT_NOW(a_wc_bounded, 1'b1, (wc_r <= WCW'(ENTRIES)))
  `BWT_ASSERT_NEXT(a_accept_busy, (in_tvalid && in_tready), (state_r == S_FIND))
  `BWT_ASSERT_NOW(a_place_only_set, (state_r == S_PLACE), (op_r == bwt_pkg::OP_SET))
  `BWT_ASSERT_NEXT(a_clear_empties, (state_r == S_FIND && go && op_r == bwt_pkg::OP_CLEAR), (valid_vec == '0 && wc_r == '0))
  `BWT_ASSERT_NOW(a_hit_is_ok, (out_valid_r && o_hit_r), (o_status_r == bwt_pkg::ST_OK))

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: breakpoint/watchpoint table testbench
// Sends set, delete, clear-all and lookup requests over the input stream. A
// table predictor kept inside the bench works out the result of each accepted
// request. Every result on the output stream is then checked field by field
// against the oldest prediction. Register settings change between phases,
// and both stream sides stall at random except in the phase run without idling.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SLOTS       = 16;
  localparam logic [31:0] WINDOW_BASE = 32'h0001_0000;
  localparam int          WINDOW_SPAN = 'h7FF;

  // kinds and opcodes that the package leaves unnamed
  localparam logic [bwt_pkg::KIND_W-1:0]   KIND_WRITE   = 3'd2;
  localparam logic [bwt_pkg::KIND_W-1:0]   KIND_EXECUTE = 3'd3;
  localparam logic [bwt_pkg::KIND_W-1:0]   KIND_RSVD5   = 3'd5;
  localparam logic [bwt_pkg::KIND_W-1:0]   KIND_RSVD7   = 3'd7;
  localparam logic [bwt_pkg::OPCODE_W-1:0] OP_RSVD5     = 3'd5;
  localparam logic [bwt_pkg::OPCODE_W-1:0] OP_RSVD7     = 3'd7;

  typedef struct packed {
    logic [bwt_pkg::OPCODE_W-1:0] op;
    logic [31:0]                  addr;
    logic [bwt_pkg::KIND_W-1:0]   kind;
    logic [bwt_pkg::LEN_W-1:0]    len;
    logic [bwt_pkg::HITS_W-1:0]   count;
    logic                         tmp;
  } bp_request_t;

  typedef struct packed {
    logic [bwt_pkg::STATUS_W-1:0] status;
    logic                         hit;
    logic [bwt_pkg::IDXO_W-1:0]   index;
    logic [bwt_pkg::KIND_W-1:0]   kind;
    logic [bwt_pkg::BASEO_W-1:0]  base;
    logic [bwt_pkg::HITS_W-1:0]   count;
    logic                         tmp;
  } bp_result_t;

  // --------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // address, length, repeat_count, temporary
  logic [5:0]  in_tuser   = '0;   // opcode, bp_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;         // entry_index, entry_type, entry_base,
                                  // entry_count, entry_temporary
  logic [3:0]  out_tuser;         // status, hit
  logic                         cfg_we    = 1'b0;
  logic [bwt_pkg::CFGI_W-1:0]   cfg_index = '0;
  logic [bwt_pkg::CFGD_W-1:0]   cfg_wdata = '0;

  breakpoint_watchpoint_table_top #(
    .ENTRIES      (SLOTS),
    .ADDRESS_BITS (32)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Table predictor state: slot contents, watch count and register copies
  // --------------------------------------------------------------------------
  logic                       slot_valid [SLOTS];
  logic                       slot_temp  [SLOTS];
  logic [31:0]                slot_base  [SLOTS];
  logic [bwt_pkg::LEN_W-1:0]  slot_len   [SLOTS];
  logic [bwt_pkg::KIND_W-1:0] slot_kind  [SLOTS];
  logic [bwt_pkg::HITS_W-1:0] slot_count [SLOTS];
  int                         watch_active = 0;

  logic                        mode_exact = 1'b0;
  logic [bwt_pkg::MASK_W-1:0]  mask_align = 4'd3;
  logic [bwt_pkg::ILEN_W-1:0]  instr_span = 5'd4;
  logic [bwt_pkg::LIMIT_W-1:0] watch_cap  = 5'd4;

  bp_result_t  pending_bp_results [$];
  logic [31:0] recent_bases [$];

  int  mismatch_count   = 0;
  int  requests_sent    = 0;
  int  results_checked  = 0;
  int  settings_applied = 0;
  int  status_seen [8];
  bit  idle_enable = 1'b1;

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_valid[s] = 1'b0;
      slot_temp[s]  = 1'b0;
    end
    for (int k = 0; k < 8; k++) status_seen[k] = 0;
  end

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #3_000_000;
    $display("FAIL breakpoint_watchpoint_table_top");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Table predictor
  // --------------------------------------------------------------------------
  function automatic bit kind_is_watch(input logic [bwt_pkg::KIND_W-1:0] k);
    return k inside {[bwt_pkg::KIND_ACCESS : bwt_pkg::KIND_PHYSICAL]};
  endfunction

  // range test without wrap: base <= a < base + len
  function automatic bit slot_covers(input int s, input logic [31:0] a);
    return (a >= slot_base[s]) && ((a - slot_base[s]) < {16'd0, slot_len[s]});
  endfunction

  // zero-length spans never collide
  function automatic bit spans_collide(input logic [31:0] a,
                                       input logic [bwt_pkg::LEN_W-1:0] la,
                                       input logic [31:0] b,
                                       input logic [bwt_pkg::LEN_W-1:0] lb);
    if (la == '0 || lb == '0) return 1'b0;
    if (a <= b) return (b - a) < {16'd0, la};
    return (a - b) < {16'd0, lb};
  endfunction

  // lowest matching slot wins; exact mode compares the base only
  function automatic int first_general_match(input logic [31:0] a);
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_valid[s] && (mode_exact ? (slot_base[s] == a) : slot_covers(s, a)))
        return s;
    end
    return -1;
  endfunction

  function automatic int first_watch_match(input logic [31:0] a);
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_valid[s] && kind_is_watch(slot_kind[s]) && slot_covers(s, a))
        return s;
    end
    return -1;
  endfunction

  function automatic void release_slot(input int s);
    if (slot_valid[s] && kind_is_watch(slot_kind[s]) && watch_active > 0)
      watch_active--;
    slot_valid[s] = 1'b0;
    slot_temp[s]  = 1'b0;
  endfunction

  function automatic bp_result_t slot_report(input int s);
    bp_result_t res;
    res        = '0;
    res.status = bwt_pkg::ST_OK;
    res.hit    = 1'b1;
    res.index  = s[bwt_pkg::IDXO_W-1:0];
    res.kind   = slot_kind[s];
    res.base   = slot_base[s];
    res.count  = slot_count[s];
    res.tmp    = slot_temp[s];
    return res;
  endfunction

  // Apply one request to the predicted table and return its result
  function automatic bp_result_t predict_bp_result(input bp_request_t r);
    bp_result_t                res;
    int                        m;
    int                        open_slot;
    logic [bwt_pkg::LEN_W-1:0] span;
    res = '0;
    case (r.op)
      bwt_pkg::OP_SET: begin
        // a covering entry goes away even when the set fails afterwards
        m = first_general_match(r.addr);
        if (m >= 0) release_slot(m);
        if (r.kind == bwt_pkg::KIND_INSTR &&
            (r.addr[bwt_pkg::MASK_W-1:0] & mask_align) != '0) begin
          res.status = bwt_pkg::ST_MISALIGN;
          return res;
        end
        if (kind_is_watch(r.kind) && watch_active >= int'(watch_cap)) begin
          res.status = bwt_pkg::ST_NO_WATCH;
          return res;
        end
        open_slot = -1;
        for (int s = 0; s < SLOTS; s++) begin
          if (!slot_valid[s]) begin
            open_slot = s;
            break;
          end
        end
        if (open_slot < 0) begin
          res.status = bwt_pkg::ST_FULL;
          return res;
        end
        span = (r.kind == bwt_pkg::KIND_INSTR) ? bwt_pkg::LEN_W'(instr_span) : r.len;
        for (int s = 0; s < SLOTS; s++) begin
          if (s != open_slot && slot_valid[s] &&
              spans_collide(r.addr, span, slot_base[s], slot_len[s])) begin
            res.status = bwt_pkg::ST_OVERLAP;
            return res;
          end
        end
        slot_base[open_slot]  = r.addr;
        slot_len[open_slot]   = span;
        slot_kind[open_slot]  = r.kind;
        slot_count[open_slot] = r.count;
        slot_temp[open_slot]  = r.tmp;
        slot_valid[open_slot] = 1'b1;
        if (kind_is_watch(r.kind)) watch_active++;
        res     = slot_report(open_slot);
        res.hit = 1'b0;
      end
      bwt_pkg::OP_DELETE: begin
        m = first_general_match(r.addr);
        if (m < 0) begin
          res.status = bwt_pkg::ST_NOT_FOUND;
        end else begin
          res = slot_report(m);
          release_slot(m);
        end
      end
      bwt_pkg::OP_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) begin
          slot_valid[s] = 1'b0;
          slot_temp[s]  = 1'b0;
        end
        watch_active = 0;
      end
      bwt_pkg::OP_LOOKUP, bwt_pkg::OP_WATCH: begin
        m = (r.op == bwt_pkg::OP_LOOKUP) ? first_general_match(r.addr)
                                         : first_watch_match(r.addr);
        if (m < 0) res.status = bwt_pkg::ST_NOT_FOUND;
        else       res = slot_report(m);
      end
      default: ;  // reserved opcodes leave the table alone and report zeros
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    bp_result_t got;
    bp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser[2:0];
      got.hit    = out_tuser[3];
      got.index  = out_tdata[3:0];
      got.kind   = out_tdata[6:4];
      got.base   = out_tdata[38:7];
      got.count  = out_tdata[54:39];
      got.tmp    = out_tdata[55];
      if (pending_bp_results.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual status %0d",
                 $time, got.status);
        mismatch_count++;
      end else begin
        want = pending_bp_results.pop_front();
        check_field("status",          32'(want.status), 32'(got.status));
        check_field("hit",             32'(want.hit),    32'(got.hit));
        check_field("entry_index",     32'(want.index),  32'(got.index));
        check_field("entry_type",      32'(want.kind),   32'(got.kind));
        check_field("entry_base",      want.base,        got.base);
        check_field("entry_count",     32'(want.count),  32'(got.count));
        check_field("entry_temporary", 32'(want.tmp),    32'(got.tmp));
        status_seen[want.status]++;
        results_checked++;
      end
    end
  end

  // Receiver: drop ready at random about 18 percent of the time unless idling is switched off
  always @(posedge clk) begin
    out_tready <= idle_enable ? ($urandom_range(99) >= 18) : 1'b1;
  end

  // --------------------------------------------------------------------------
  // Shared sender and phase helpers
  // --------------------------------------------------------------------------
  function automatic bp_request_t make_request(input logic [bwt_pkg::OPCODE_W-1:0] op,
                                               input logic [31:0] addr,
                                               input logic [bwt_pkg::KIND_W-1:0] kind,
                                               input logic [bwt_pkg::LEN_W-1:0] len,
                                               input logic [bwt_pkg::HITS_W-1:0] count,
                                               input logic tmp);
    bp_request_t r;
    r.op    = op;
    r.addr  = addr;
    r.kind  = kind;
    r.len   = len;
    r.count = count;
    r.tmp   = tmp;
    return r;
  endfunction

  // Drive one request, hold it until accepted, then log its predicted result.
  // A random gap drops valid first; otherwise valid stays high back to back.
  task automatic send_request(input bp_request_t r);
    if (idle_enable && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tdata  <= {7'd0, r.tmp, r.count, r.len, r.addr};
    in_tuser  <= {r.kind, r.op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_bp_results.push_back(predict_bp_result(r));
    requests_sent++;
  endtask

  // Hold off the sender until every predicted result has come back, then
  // let the chain settle. Anything still missing after the guard is a failure.
  task automatic wait_for_results();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending_bp_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_bp_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               pending_bp_results.size());
      mismatch_count++;
      pending_bp_results.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  // Write all four registers on an idle block, keeping cfg_we high throughout
  task automatic apply_settings(input logic exact,
                                input logic [bwt_pkg::MASK_W-1:0] align,
                                input logic [bwt_pkg::ILEN_W-1:0] ilen,
                                input logic [bwt_pkg::LIMIT_W-1:0] wlimit);
    logic [bwt_pkg::CFGI_W-1:0] reg_ids [4];
    logic [bwt_pkg::CFGD_W-1:0] values  [4];
    reg_ids = '{bwt_pkg::REG_EXACT, bwt_pkg::REG_ALIGN, bwt_pkg::REG_ILEN,
                bwt_pkg::REG_WLIMIT};
    values  = '{bwt_pkg::CFGD_W'(exact), bwt_pkg::CFGD_W'(align),
                bwt_pkg::CFGD_W'(ilen), bwt_pkg::CFGD_W'(wlimit)};
    wait_for_results();
    cfg_we <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index <= reg_ids[k];
      cfg_wdata <= values[k];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    mode_exact = exact;
    mask_align = align;
    instr_span = ilen;
    watch_cap  = wlimit;
    settings_applied++;
  endtask

  // --------------------------------------------------------------------------
  // Random request generation
  // --------------------------------------------------------------------------
  function automatic logic [bwt_pkg::LEN_W-1:0] random_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3)  return '0;
    if (roll < 73) return bwt_pkg::LEN_W'($urandom_range(1, 16));
    if (roll < 95) return bwt_pkg::LEN_W'($urandom_range(17, 128));
    return bwt_pkg::LEN_W'($urandom_range(1, 65535));
  endfunction

  // Probe near bases that were set recently, so lookups and deletes hit often
  function automatic logic [31:0] probe_address();
    logic [31:0] a;
    if (recent_bases.size() != 0 && $urandom_range(99) < 70) begin
      a = recent_bases[$urandom_range(recent_bases.size() - 1)];
      if ($urandom_range(99) < 40) a += $urandom_range(15);
    end else begin
      a = WINDOW_BASE + $urandom_range(WINDOW_SPAN);
    end
    return a;
  endfunction

  function automatic bp_request_t random_request();
    bp_request_t r;
    int          roll;
    r       = '0;
    r.count = bwt_pkg::HITS_W'($urandom);
    r.tmp   = 1'($urandom_range(1));
    r.len   = random_length();
    r.kind  = bwt_pkg::KIND_W'($urandom_range(bwt_pkg::KIND_INSTR, bwt_pkg::KIND_PHYSICAL));
    roll    = $urandom_range(99);
    if (roll < 50) begin
      r.op = bwt_pkg::OP_SET;
      roll = $urandom_range(99);
      if (roll < 35) begin
        r.kind = bwt_pkg::KIND_INSTR;
      end else if (roll < 94) begin
        r.kind = bwt_pkg::KIND_W'($urandom_range(bwt_pkg::KIND_ACCESS,
                                                 bwt_pkg::KIND_PHYSICAL));
      end else begin
        r.kind = bwt_pkg::KIND_W'($urandom_range(KIND_RSVD5, KIND_RSVD7));
      end
      r.addr = ($urandom_range(99) < 85) ? WINDOW_BASE + $urandom_range(WINDOW_SPAN)
                                         : $urandom;
      // mostly honor the current alignment so instruction entries get in
      if (r.kind == bwt_pkg::KIND_INSTR && $urandom_range(99) < 75)
        r.addr[bwt_pkg::MASK_W-1:0] = r.addr[bwt_pkg::MASK_W-1:0] & ~mask_align;
      recent_bases.push_back(r.addr);
      if (recent_bases.size() > SLOTS) void'(recent_bases.pop_front());
    end else if (roll < 60) begin
      r.op   = bwt_pkg::OP_DELETE;
      r.addr = probe_address();
    end else if (roll < 77) begin
      r.op   = bwt_pkg::OP_LOOKUP;
      r.addr = probe_address();
    end else if (roll < 95) begin
      r.op   = bwt_pkg::OP_WATCH;
      r.addr = probe_address();
    end else if (roll < 98) begin
      r.op   = bwt_pkg::OP_CLEAR;
      r.addr = $urandom;
    end else begin
      r.op   = bwt_pkg::OPCODE_W'($urandom_range(OP_RSVD5, OP_RSVD7));
      r.addr = $urandom;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Plain set, freeing on set, misalignment, overlap, range end, lookups
  task automatic test_basic_ops();
    send_request(make_request(bwt_pkg::OP_SET, 32'h0000_1000, bwt_pkg::KIND_INSTR,
                              16'h0000, 16'hFFFF, 1'b1));
    // covering instruction entry is freed, then the set fails on alignment
    send_request(make_request(bwt_pkg::OP_SET, 32'h0000_1002, bwt_pkg::KIND_INSTR,
                              16'hFFFF, 16'h1234, 1'b0));
    send_request(make_request(bwt_pkg::OP_LOOKUP, 32'h0000_1000, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
    send_request(make_request(bwt_pkg::OP_SET, 32'h0000_2000, bwt_pkg::KIND_ACCESS,
                              16'h0010, 16'h0000, 1'b0));
    send_request(make_request(bwt_pkg::OP_SET, 32'h0000_2008, KIND_WRITE,
                              16'h0008, 16'h5A5A, 1'b1));
    // partly overlaps the write watch at 0x2008
    send_request(make_request(bwt_pkg::OP_SET, 32'h0000_2004, KIND_EXECUTE,
                              16'h0008, 16'h0001, 1'b0));
    send_request(make_request(bwt_pkg::OP_SET, 32'h0000_3000, bwt_pkg::KIND_PHYSICAL,
                              16'h0100, 16'hA5A5, 1'b1));
    // top of the address space: no wrap past 0xFFFFFFFF
    send_request(make_request(bwt_pkg::OP_SET, 32'hFFFF_FFF0, bwt_pkg::KIND_ACCESS,
                              16'hFFFF, 16'h8000, 1'b1));
    send_request(make_request(bwt_pkg::OP_WATCH, 32'hFFFF_FFFF, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
    send_request(make_request(bwt_pkg::OP_LOOKUP, 32'h0000_3080, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
  endtask

  // Zero length, watch limit, reserved kinds and opcodes, exact mode, clear all
  task automatic test_special_cases();
    send_request(make_request(bwt_pkg::OP_SET, 32'h0000_5000, bwt_pkg::KIND_ACCESS,
                              16'h0000, 16'h0042, 1'b0));
    send_request(make_request(bwt_pkg::OP_WATCH, 32'h0000_5000, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
    // zero-length neighbor does not block this one
    send_request(make_request(bwt_pkg::OP_SET, 32'h0000_5000, bwt_pkg::KIND_INSTR,
                              16'd0, 16'h0777, 1'b1));
    // four watches are live now: the limit refuses another
    send_request(make_request(bwt_pkg::OP_SET, 32'h0000_6000, bwt_pkg::KIND_ACCESS,
                              16'h0004, 16'd1, 1'b0));
    send_request(make_request(bwt_pkg::OP_SET, 32'h0000_7001, KIND_RSVD5,
                              16'h0004, 16'h0055, 1'b0));
    send_request(make_request(bwt_pkg::OP_WATCH, 32'h0000_7001, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
    send_request(make_request(bwt_pkg::OP_LOOKUP, 32'h0000_7002, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
    send_request(make_request(bwt_pkg::OP_DELETE, 32'h0000_2009, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
    send_request(make_request(bwt_pkg::OP_DELETE, 32'h0000_2009, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
    send_request(make_request(OP_RSVD5, 32'hFFFF_FFFF, KIND_RSVD7,
                              16'hFFFF, 16'hFFFF, 1'b1));
    send_request(make_request(OP_RSVD7, 32'h0000_5000, bwt_pkg::KIND_INSTR,
                              16'd1, 16'd1, 1'b1));
    // exact mode: two entries share base 0x5000, the lower slot must win
    apply_settings(1'b1, 4'd3, 5'd4, 5'd4);
    send_request(make_request(bwt_pkg::OP_LOOKUP, 32'h0000_5000, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
    apply_settings(1'b0, 4'd3, 5'd4, 5'd4);
    send_request(make_request(bwt_pkg::OP_CLEAR, 32'h0000_0000, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
    send_request(make_request(bwt_pkg::OP_LOOKUP, 32'h0000_3080, bwt_pkg::KIND_INSTR,
                              16'd0, 16'd0, 1'b0));
  endtask

  // Random traffic under the current settings; pause once midway until drained
  task automatic test_random_traffic(input int count, input bit with_idle);
    idle_enable = with_idle;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_for_results();
      send_request(random_request());
    end
    idle_enable = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_special_cases();

    // reset settings, stalls on both sides
    test_random_traffic(85, 1'b1);
    // exact match, no alignment, instruction length 16, every slot may watch;
    // run this one with no idling at all
    apply_settings(1'b1, 4'd0, 5'd16, 5'd16);
    test_random_traffic(85, 1'b0);
    // strictest alignment, narrowest instruction, watches refused
    apply_settings(1'b0, 4'd15, 5'd1, 5'd0);
    test_random_traffic(85, 1'b1);
    repeat (2) begin
      apply_settings(1'($urandom_range(1)), bwt_pkg::MASK_W'($urandom_range(15)),
                     bwt_pkg::ILEN_W'($urandom_range(1, 16)),
                     bwt_pkg::LIMIT_W'($urandom_range(16)));
      test_random_traffic(85, 1'b1);
    end

    wait_for_results();
    $display("Checked %0d results for %0d requests over %0d register settings",
             results_checked, requests_sent, settings_applied + 1);
    $display("Outcomes: ok %0d, not found %0d, full %0d, misaligned %0d, no watch %0d,",
             status_seen[bwt_pkg::ST_OK], status_seen[bwt_pkg::ST_NOT_FOUND],
             status_seen[bwt_pkg::ST_FULL], status_seen[bwt_pkg::ST_MISALIGN],
             status_seen[bwt_pkg::ST_NO_WATCH]);
    $display("          overlap %0d", status_seen[bwt_pkg::ST_OVERLAP]);
    if (mismatch_count == 0) begin
      $display("PASS breakpoint_watchpoint_table_top");
    end else begin
      $display("FAIL breakpoint_watchpoint_table_top");
    end
    $finish;
  end

endmodule
